### sv/gia_pkg.sv
// ----------------------------------------------------------------------------
// gia_pkg
// Shared widths, codes and controller/datapath command and status types for
// the generational id allocator.
// ----------------------------------------------------------------------------
package gia_pkg;

    // Fixed payload widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 10;
    localparam int VER_W  = 12;
    localparam int STAT_W = 2;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    // Response status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    // Source of the response index/version
    typedef enum logic [1:0] {
        RES_ECHO  = 2'd0,
        RES_FRESH = 2'd1,
        RES_POP   = 2'd2
    } t_res_sel;

    // Controller -> datapath
    typedef struct packed {
        logic     clr_step;
        logic     load;
        logic     pop;
        logic     fresh;
        logic     rel_commit;
        logic     emit;
        t_res_sel res_sel;
        t_status  res_status;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            stack_nonempty;
        logic            fresh_avail;
        logic            id_valid;
        logic            out_free;
        logic            clr_done;
    } t_dp_sts;

endpackage

### sv/gia_channels.sv
// ----------------------------------------------------------------------------
// gia_channels
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface gia_req_if;
    logic                         valid;
    logic                         ready;
    logic [gia_pkg::OP_W-1:0]     opcode;
    logic [gia_pkg::IDX_W-1:0]    req_index;
    logic [gia_pkg::VER_W-1:0]    req_version;

    modport source (output valid, output opcode, output req_index, output req_version,
                    input ready);
    modport sink   (input valid, input opcode, input req_index, input req_version,
                    output ready);
endinterface

interface gia_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gia_pkg::IDX_W-1:0]    out_index;
    logic [gia_pkg::VER_W-1:0]    out_version;
    logic [gia_pkg::STAT_W-1:0]   status;

    modport source (output valid, output out_index, output out_version, output status,
                    input ready);
    modport sink   (input valid, input out_index, input out_version, input status,
                    output ready);
endinterface

### sv/gia_ram.sv
// ----------------------------------------------------------------------------
// gia_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module gia_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gia_ctrl.sv
// ----------------------------------------------------------------------------
// gia_ctrl
// Sequencer for the allocator: clearing pass after reset, request capture,
// execute, and the extra generation lookup for a free-stack pop.
// ----------------------------------------------------------------------------
module gia_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  gia_pkg::t_dp_sts i_sts,
    output gia_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_ready;
    gia_pkg::t_dp_cmd cmd;

    // Next state and command decode
    always_comb begin
        cmd            = '0;
        cmd.res_sel    = gia_pkg::RES_ECHO;
        cmd.res_status = gia_pkg::ST_INVALID;
        n_state        = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    gia_pkg::OP_ALLOC: begin
                        if (i_sts.stack_nonempty) begin
                            // reuse: pop now, generation arrives next cycle
                            cmd.pop = 1'b1;
                            n_state = S_POP;
                        end else if (i_sts.out_free) begin
                            cmd.emit = 1'b1;
                            if (i_sts.fresh_avail) begin
                                cmd.fresh      = 1'b1;
                                cmd.res_sel    = gia_pkg::RES_FRESH;
                                cmd.res_status = gia_pkg::ST_OK;
                            end else begin
                                cmd.res_status = gia_pkg::ST_EXHAUSTED;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    gia_pkg::OP_RELEASE: begin
                        if (i_sts.out_free) begin
                            cmd.emit       = 1'b1;
                            cmd.rel_commit = i_sts.id_valid;
                            cmd.res_status = i_sts.id_valid ? gia_pkg::ST_OK
                                                            : gia_pkg::ST_INVALID;
                            n_state        = S_IDLE;
                        end
                    end
                    gia_pkg::OP_CHECK: begin
                        if (i_sts.out_free) begin
                            cmd.emit       = 1'b1;
                            cmd.res_status = i_sts.id_valid ? gia_pkg::ST_OK
                                                            : gia_pkg::ST_INVALID;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        // unused opcode: echo, invalid
                        if (i_sts.out_free) begin
                            cmd.emit = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.res_sel    = gia_pkg::RES_POP;
                    cmd.res_status = gia_pkg::ST_OK;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;
    assign o_cmd      = cmd;

endmodule

### sv/gia_dp.sv
// ----------------------------------------------------------------------------
// gia_dp
// Allocator datapath: generation RAM, free-stack RAM, counters, id check and
// the response register.
// ----------------------------------------------------------------------------
module gia_dp #(
    parameter int MAX_IDS      = 1024,
    parameter int PAGE_SHIFT   = 6,
    parameter int VERSION_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gia_pkg::t_dp_cmd            i_cmd,
    output gia_pkg::t_dp_sts            o_sts,
    input  logic [gia_pkg::OP_W-1:0]    i_opcode,
    input  logic [gia_pkg::IDX_W-1:0]   i_req_index,
    input  logic [gia_pkg::VER_W-1:0]   i_req_version,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gia_pkg::IDX_W-1:0]   o_out_index,
    output logic [gia_pkg::VER_W-1:0]   o_out_version,
    output logic [gia_pkg::STAT_W-1:0]  o_status
);

    localparam int IW = $clog2(MAX_IDS);
    localparam int AW = IW + 1;
    localparam int GW = VERSION_BITS;
    localparam int XW = (AW > gia_pkg::IDX_W) ? AW : gia_pkg::IDX_W;
    localparam int CW = (GW > gia_pkg::VER_W) ? GW : gia_pkg::VER_W;
    localparam logic [CW-1:0] VMASK = CW'((65'd1 << GW) - 65'd1);
    localparam logic [gia_pkg::IDX_W-1:0] PAGE_MASK =
        gia_pkg::IDX_W'(~((32'd1 << PAGE_SHIFT) - 32'd1));

    // Captured request
    logic [gia_pkg::OP_W-1:0]  r_op;
    logic [gia_pkg::IDX_W-1:0] r_idx;
    logic [gia_pkg::VER_W-1:0] r_ver;

    // Counters
    logic [AW-1:0] r_free_count;
    logic [AW-1:0] r_fresh_next;
    logic [IW-1:0] r_clr_addr;

    // Response register
    logic                        r_out_valid;
    logic [gia_pkg::IDX_W-1:0]   r_out_index;
    logic [gia_pkg::VER_W-1:0]   r_out_version;
    logic [gia_pkg::STAT_W-1:0]  r_status;

    // RAM ports
    logic          gen_we;
    logic [IW-1:0] gen_waddr;
    logic [GW-1:0] gen_wdata;
    logic          gen_re;
    logic [IW-1:0] gen_raddr;
    logic [GW-1:0] gen_rdata;
    logic          stk_we;
    logic [IW-1:0] stk_rdata;

    logic                      out_free;
    logic                      push_ok;
    logic [gia_pkg::IDX_W-1:0] page_base;
    logic                      idx_in_range;
    logic                      page_ok;
    logic                      ver_match;
    logic                      id_valid;

    assign out_free = !r_out_valid || i_out_ready;
    assign push_ok  = r_free_count < AW'(MAX_IDS);

    // Id check against the stored generation
    assign page_base    = r_idx & PAGE_MASK;
    assign idx_in_range = XW'(r_idx) < XW'(MAX_IDS);
    assign page_ok      = XW'(page_base) < XW'(r_fresh_next);
    assign ver_match    = CW'(gen_rdata) == (CW'(r_ver) & VMASK);
    assign id_valid     = idx_in_range && page_ok && ver_match;

    // Generation RAM: clear sweep or bump on write, request or pop on read
    assign gen_we    = i_cmd.clr_step || i_cmd.rel_commit;
    assign gen_waddr = i_cmd.clr_step ? r_clr_addr : IW'(r_idx);
    assign gen_wdata = i_cmd.clr_step ? '0 : (gen_rdata + GW'(1));
    assign gen_re    = i_cmd.load || i_cmd.pop;
    assign gen_raddr = i_cmd.pop ? stk_rdata : IW'(i_req_index);

    assign stk_we = i_cmd.rel_commit && push_ok;

    gia_ram #(
        .WIDTH (GW),
        .DEPTH (MAX_IDS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_re    (gen_re),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    // Free stack: top entry is read at request capture
    gia_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_IDS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (IW'(r_free_count)),
        .i_wdata (IW'(r_idx)),
        .i_re    (i_cmd.load),
        .i_raddr (IW'(r_free_count - AW'(1))),
        .o_rdata (stk_rdata)
    );

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_idx <= i_req_index;
            r_ver <= i_req_version;
        end
    end

    // Counters and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= '0;
            r_fresh_next <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (i_cmd.pop) begin
                r_free_count <= r_free_count - AW'(1);
            end else if (stk_we) begin
                r_free_count <= r_free_count + AW'(1);
            end
            if (i_cmd.fresh) begin
                r_fresh_next <= r_fresh_next + AW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.res_status;
            case (i_cmd.res_sel)
                gia_pkg::RES_POP: begin
                    r_out_index   <= gia_pkg::IDX_W'(stk_rdata);
                    r_out_version <= gia_pkg::VER_W'(gen_rdata);
                end
                gia_pkg::RES_FRESH: begin
                    r_out_index   <= gia_pkg::IDX_W'(r_fresh_next);
                    r_out_version <= '0;
                end
                default: begin
                    r_out_index   <= r_idx;
                    r_out_version <= '0;
                end
            endcase
        end
    end

    assign o_sts.op             = r_op;
    assign o_sts.stack_nonempty = (r_free_count != '0);
    assign o_sts.fresh_avail    = r_fresh_next < AW'(MAX_IDS);
    assign o_sts.id_valid       = id_valid;
    assign o_sts.out_free       = out_free;
    assign o_sts.clr_done       = (r_clr_addr == IW'(MAX_IDS - 1));

    assign o_out_valid   = r_out_valid;
    assign o_out_index   = r_out_index;
    assign o_out_version = r_out_version;
    assign o_status      = r_status;

endmodule

### sv/generational_id_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_id_allocator_core
// Hands out index/generation ids from a LIFO free stack or a fresh counter,
// and releases and checks them against a per-index generation table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the generation RAM, one
// entry per cycle, and takes no request beat until it is done. Then each
// request passes through capture (with the RAM read) and execute, since the
// generation RAM has a registered read; an allocate that reuses an index
// from the free stack adds a pop step, since the generation of the popped
// index is read from the same RAM port after the stack read. One request is
// in flight at a time. The response sits in an output register, so the next
// request beat is taken while an earlier response waits; the block stalls
// in its last step only while that register is still full.
module generational_id_allocator_core #(
    parameter int MAX_IDS      = 1024,
    parameter int PAGE_SHIFT   = 6,
    parameter int VERSION_BITS = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    gia_req_if.sink   i_req,
    gia_rsp_if.source o_rsp
);

    gia_pkg::t_dp_cmd cmd;
    gia_pkg::t_dp_sts sts;

    // Sequencer
    gia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Tables, counters and response register
    gia_dp #(
        .MAX_IDS      (MAX_IDS),
        .PAGE_SHIFT   (PAGE_SHIFT),
        .VERSION_BITS (VERSION_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_req.opcode),
        .i_req_index   (i_req.req_index),
        .i_req_version (i_req.req_version),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_out_index   (o_rsp.out_index),
        .o_out_version (o_rsp.out_version),
        .o_status      (o_rsp.status)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational id allocator. A scoreboard keeps
// its own generation table, free stack and fresh counter, predicts one
// response per request beat and compares every response beat field by field.
// Traffic covers directed corner cases and mixed allocate/release/check
// sequences with stale ids, ids in touched pages and random noise.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [gia_pkg::IDX_W-1:0] id_idx;
    logic [gia_pkg::VER_W-1:0] id_ver;
    gia_pkg::t_status          status;
} id_rsp_t;

// Predicts allocator responses and checks them in order
class id_alloc_scoreboard #(int MAX_IDS = 1024, int PAGE_SHIFT = 6, int VERSION_BITS = 12);
    localparam longint unsigned VER_MASK = (64'd1 << VERSION_BITS) - 64'd1;

    logic [gia_pkg::VER_W-1:0] gen_tbl  [MAX_IDS];
    logic [gia_pkg::IDX_W-1:0] free_stk [MAX_IDS];
    int unsigned               free_cnt;
    int unsigned               fresh_nxt;
    id_rsp_t                   pending [$];
    int unsigned               errors;
    int unsigned               n_checked;
    int unsigned               n_exhausted;
    int unsigned               n_dropped_push;
    int unsigned               n_wraps;

    function new();
        foreach (gen_tbl[i]) gen_tbl[i] = '0;
        free_cnt       = 0;
        fresh_nxt      = 0;
        errors         = 0;
        n_checked      = 0;
        n_exhausted    = 0;
        n_dropped_push = 0;
        n_wraps        = 0;
    endfunction

    // Index in range, page already touched by a fresh allocate, generation current
    function bit id_current(int unsigned idx, logic [gia_pkg::VER_W-1:0] ver);
        int unsigned page_base;
        if (idx >= MAX_IDS) return 1'b0;
        page_base = (idx >> PAGE_SHIFT) << PAGE_SHIFT;
        if (page_base >= fresh_nxt) return 1'b0;
        return 64'(gen_tbl[idx]) == (64'(ver) & VER_MASK);
    endfunction

    // Called on every accepted request beat; returns the predicted response
    function id_rsp_t note_request(logic [gia_pkg::OP_W-1:0] op,
                                   logic [gia_pkg::IDX_W-1:0] idx,
                                   logic [gia_pkg::VER_W-1:0] ver);
        id_rsp_t     r;
        int unsigned got;
        r.id_idx = idx;
        r.id_ver = '0;
        r.status = gia_pkg::ST_INVALID;
        case (op)
            gia_pkg::OP_ALLOC: begin
                if (free_cnt > 0) begin
                    // reuse the most recently released index
                    free_cnt--;
                    got      = 32'(free_stk[free_cnt]);
                    r.id_idx = gia_pkg::IDX_W'(got);
                    r.id_ver = gen_tbl[got];
                    r.status = gia_pkg::ST_OK;
                end else if (fresh_nxt < MAX_IDS) begin
                    // fresh index always goes out with generation zero
                    r.id_idx = gia_pkg::IDX_W'(fresh_nxt);
                    r.status = gia_pkg::ST_OK;
                    fresh_nxt++;
                end else begin
                    r.status = gia_pkg::ST_EXHAUSTED;
                    n_exhausted++;
                end
            end
            gia_pkg::OP_RELEASE: begin
                if (id_current(32'(idx), ver)) begin
                    gen_tbl[idx] = gia_pkg::VER_W'((64'(gen_tbl[idx]) + 64'd1) & VER_MASK);
                    if (gen_tbl[idx] == '0) n_wraps++;
                    // a full stack drops the push but the bump stands
                    if (free_cnt < MAX_IDS) begin
                        free_stk[free_cnt] = idx;
                        free_cnt++;
                    end else begin
                        n_dropped_push++;
                    end
                    r.status = gia_pkg::ST_OK;
                end
            end
            gia_pkg::OP_CHECK: begin
                r.status = id_current(32'(idx), ver) ? gia_pkg::ST_OK : gia_pkg::ST_INVALID;
            end
            default: ;
        endcase
        pending.push_back(r);
        return r;
    endfunction

    // Called on every accepted response beat
    function void check_response(logic [gia_pkg::IDX_W-1:0]  idx,
                                 logic [gia_pkg::VER_W-1:0]  ver,
                                 logic [gia_pkg::STAT_W-1:0] st);
        id_rsp_t e;
        n_checked++;
        if (pending.size() == 0) begin
            $error("response beat with nothing outstanding: index %0d version %0d status %0d",
                   idx, ver, st);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (idx !== e.id_idx) begin
            $error("out_index: expected %0d, got %0d", e.id_idx, idx);
            errors++;
        end
        if (ver !== e.id_ver) begin
            $error("out_version: expected %0d, got %0d", e.id_ver, ver);
            errors++;
        end
        if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int MAX_IDS      = 1024;
    localparam int PAGE_SHIFT   = 6;
    localparam int VERSION_BITS = 12;
    localparam logic [gia_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 21;
    localparam int N_MIXED      = 376;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [gia_pkg::IDX_W-1:0] idx;
        logic [gia_pkg::VER_W-1:0] ver;
    } held_id_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   quiet;

    gia_req_if req_ch();
    gia_rsp_if rsp_ch();

    generational_id_allocator_core #(
        .MAX_IDS      (MAX_IDS),
        .PAGE_SHIFT   (PAGE_SHIFT),
        .VERSION_BITS (VERSION_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    id_alloc_scoreboard #(MAX_IDS, PAGE_SHIFT, VERSION_BITS) sb;
    held_id_t live_ids [$];
    held_id_t retired_ids [$];

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Response side: random backpressure, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.out_index, rsp_ch.out_version, rsp_ch.status);
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Drive one request beat, with random gaps ahead of it; valid stays up
    // across back-to-back beats
    task automatic send_req(input logic [gia_pkg::OP_W-1:0] op,
                            input logic [gia_pkg::IDX_W-1:0] idx,
                            input logic [gia_pkg::VER_W-1:0] ver, output id_rsp_t predicted);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.req_index   <= idx;
        req_ch.req_version <= ver;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = sb.note_request(op, idx, ver);
    endtask

    task automatic issue(input logic [gia_pkg::OP_W-1:0] op,
                         input logic [gia_pkg::IDX_W-1:0] idx,
                         input logic [gia_pkg::VER_W-1:0] ver);
        id_rsp_t p;
        send_req(op, idx, ver, p);
    endtask

    // Allocate with junk in the id fields; keep what we got
    task automatic alloc_one();
        id_rsp_t p;
        send_req(gia_pkg::OP_ALLOC, gia_pkg::IDX_W'($urandom_range(0, MAX_IDS - 1)),
                 gia_pkg::VER_W'($urandom_range(0, 4095)), p);
        if (p.status == gia_pkg::ST_OK) live_ids.push_back('{p.id_idx, p.id_ver});
    endtask

    // Mostly well-formed allocate/release/check traffic, plus stale ids and noise
    task automatic run_mixed(input int n);
        id_rsp_t     p;
        held_id_t    h;
        int          k;
        int unsigned r;
        int unsigned hi;
        logic [gia_pkg::IDX_W-1:0] idx;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 38 || (r < 75 && live_ids.size() == 0)) begin
                alloc_one();
            end else if (r < 60) begin
                // release a held id
                k = int'($urandom_range(0, live_ids.size() - 1));
                h = live_ids[k];
                live_ids.delete(k);
                send_req(gia_pkg::OP_RELEASE, h.idx, h.ver, p);
                retired_ids.push_back(h);
                if (retired_ids.size() > 32) void'(retired_ids.pop_front());
            end else if (r < 75) begin
                k = int'($urandom_range(0, live_ids.size() - 1));
                issue(gia_pkg::OP_CHECK, live_ids[k].idx, live_ids[k].ver);
            end else if (r < 83 && retired_ids.size() > 0) begin
                // stale id: release again or check
                k = int'($urandom_range(0, retired_ids.size() - 1));
                issue($urandom_range(0, 1) ? gia_pkg::OP_RELEASE : gia_pkg::OP_CHECK,
                      retired_ids[k].idx, retired_ids[k].ver);
            end else if (r < 90 && sb.fresh_nxt > 0) begin
                // somewhere in a touched page, mostly with the current generation
                hi = (((sb.fresh_nxt - 1) >> PAGE_SHIFT) << PAGE_SHIFT) + (1 << PAGE_SHIFT) - 1;
                if (hi > MAX_IDS - 1) hi = MAX_IDS - 1;
                idx = gia_pkg::IDX_W'($urandom_range(0, hi));
                issue($urandom_range(0, 1) ? gia_pkg::OP_RELEASE : gia_pkg::OP_CHECK, idx,
                      sb.gen_tbl[idx] + gia_pkg::VER_W'($urandom_range(0, 3) == 0));
            end else if (r < 96) begin
                issue(gia_pkg::OP_W'($urandom_range(0, 3)),
                      gia_pkg::IDX_W'($urandom_range(0, MAX_IDS - 1)),
                      gia_pkg::VER_W'($urandom_range(0, 4095)));
            end else begin
                issue(OP_UNUSED, gia_pkg::IDX_W'($urandom_range(0, MAX_IDS - 1)),
                      gia_pkg::VER_W'($urandom_range(0, 4095)));
            end
        end
    endtask

    // Overall time limit
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb    = new();
        quiet = 1'b0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = gia_pkg::OP_ALLOC;
        req_ch.req_index   = '0;
        req_ch.req_version = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: untouched pages, unused opcode, touched but unallocated
        // indices, stale ids, reuse order, fresh index with a bumped generation
        issue(gia_pkg::OP_CHECK,   10'd0,    12'd0);
        issue(gia_pkg::OP_RELEASE, 10'd0,    12'd0);
        issue(OP_UNUSED,           10'd1023, 12'd4095);
        issue(gia_pkg::OP_ALLOC,   10'd1023, 12'd4095);
        issue(gia_pkg::OP_CHECK,   10'd0,    12'd0);
        issue(gia_pkg::OP_CHECK,   10'd63,   12'd0);
        issue(gia_pkg::OP_CHECK,   10'd64,   12'd0);
        issue(gia_pkg::OP_RELEASE, 10'd5,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_RELEASE, 10'd0,    12'd1);
        issue(gia_pkg::OP_RELEASE, 10'd0,    12'd0);
        issue(gia_pkg::OP_CHECK,   10'd0,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_RELEASE, 10'd3,    12'd0);
        issue(gia_pkg::OP_RELEASE, 10'd7,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_ALLOC,   10'd0,    12'd0);
        issue(gia_pkg::OP_CHECK,   10'd3,    12'd1);
        issue(gia_pkg::OP_CHECK,   10'd1023, 12'd4095);
        issue(gia_pkg::OP_RELEASE, 10'd1023, 12'd4095);
        issue(OP_UNUSED,           10'd0,    12'd0);

        // Mixed traffic; second half without any idling on either side
        run_mixed(N_MIXED / 2);
        quiet = 1'b1;
        run_mixed(N_MIXED / 2);
        quiet = 1'b0;

        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d responses over directed corner cases and mixed traffic,",
                 sb.n_checked);
        $display("with %0d exhausted allocates, %0d dropped pushes and %0d generation wraps.",
                 sb.n_exhausted, sb.n_dropped_push, sb.n_wraps);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### filelist.f
sv/gia_pkg.sv
sv/gia_channels.sv
sv/gia_ram.sv
sv/gia_ctrl.sv
sv/gia_dp.sv
sv/generational_id_allocator_core.sv
sim/tb_top.sv
